### hw/rtl/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// shared codes, register reset values and controller/datapath bundles for the
// character lcd nibble writer
// ----------------------------------------------------------------------------
package clnw_pkg;

	// operation codes on the func field
	localparam logic [2:0] FUNC_CHAR   = 3'd0;
	localparam logic [2:0] FUNC_STRING = 3'd1;
	localparam logic [2:0] FUNC_CURSOR = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_INIT   = 3'd4;

	// cursor rows
	localparam logic [1:0] ROW_FIRST  = 2'd0;
	localparam logic [1:0] ROW_SECOND = 2'd1;

	// configuration register indexes
	localparam logic [2:0] CFG_INIT_1 = 3'd0;
	localparam logic [2:0] CFG_INIT_2 = 3'd1;
	localparam logic [2:0] CFG_INIT_3 = 3'd2;
	localparam logic [2:0] CFG_INIT_4 = 3'd3;
	localparam logic [2:0] CFG_INIT_5 = 3'd4;
	localparam logic [2:0] CFG_CLEAR  = 3'd5;

	// register reset values
	localparam logic [7:0] RST_INIT_1 = 8'h33;
	localparam logic [7:0] RST_INIT_2 = 8'h32;
	localparam logic [7:0] RST_INIT_3 = 8'h28;
	localparam logic [7:0] RST_INIT_4 = 8'h0C;
	localparam logic [7:0] RST_INIT_5 = 8'h01;
	localparam logic [7:0] RST_CLEAR  = 8'h01;

	// fixed command bytes
	localparam logic [7:0] CMD_HOME  = 8'h80;
	localparam logic [7:0] CMD_LINE2 = 8'hC0;
	localparam logic [7:0] CMD_ROW1  = 8'h40;

	// wait lengths in milliseconds
	localparam logic [3:0] WAIT_LONG  = 4'd15;
	localparam logic [3:0] WAIT_SHORT = 4'd2;

	// one segment of the output sequence: a byte (two strobes) or a wait
	typedef enum logic [3:0] {
		SEG_NONE,
		SEG_DATA,
		SEG_LINE2,
		SEG_CLEAR,
		SEG_HOME,
		SEG_CURSOR,
		SEG_INIT_1,
		SEG_INIT_2,
		SEG_INIT_3,
		SEG_INIT_4,
		SEG_INIT_5,
		SEG_WAIT_A,
		SEG_WAIT_B,
		SEG_WAIT_C
	} clnw_seg_t;

	typedef struct packed {
		logic      capture;
		logic      load;
		clnw_seg_t seg;
		logic      low;
		logic      last;
	} clnw_cmd_t;

	typedef struct packed {
		logic line_hit;
		logic wrap_hit;
	} clnw_sts_t;

endpackage

### hw/rtl/clnw_ctrl.sv
// ----------------------------------------------------------------------------
// clnw_ctrl
// sequencer for one operation's segments, one result per cycle unless stalled
// ----------------------------------------------------------------------------
module clnw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          func,
	input  logic [7:0]          data_byte,
	input  logic [1:0]          row,
	output logic                out_valid,
	input  logic                out_stall,
	input  clnw_pkg::clnw_sts_t sts,
	output clnw_pkg::clnw_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t              state_q;
	clnw_pkg::clnw_seg_t seg_q;
	clnw_pkg::clnw_seg_t seg_next;
	clnw_pkg::clnw_seg_t seg_first;
	logic                low_q;
	logic [2:0]          func_q;
	logic                out_valid_q;
	logic                accept;
	logic                emit_go;
	logic                is_wait;
	logic                step_end;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// first segment of a new item
	always_comb begin
		case (func)
			clnw_pkg::FUNC_CHAR:   seg_first = clnw_pkg::SEG_DATA;
			clnw_pkg::FUNC_STRING: seg_first = (data_byte != 8'd0) ?
				clnw_pkg::SEG_DATA : clnw_pkg::SEG_NONE;
			clnw_pkg::FUNC_CURSOR: seg_first = (row == clnw_pkg::ROW_FIRST ||
				row == clnw_pkg::ROW_SECOND) ? clnw_pkg::SEG_CURSOR : clnw_pkg::SEG_NONE;
			clnw_pkg::FUNC_CLEAR:  seg_first = clnw_pkg::SEG_CLEAR;
			clnw_pkg::FUNC_INIT:   seg_first = clnw_pkg::SEG_WAIT_A;
			default:               seg_first = clnw_pkg::SEG_NONE;
		endcase
	end

	// segment after the current one
	always_comb begin
		case (seg_q)
			clnw_pkg::SEG_DATA: begin
				if (func_q == clnw_pkg::FUNC_STRING && sts.line_hit)
					seg_next = clnw_pkg::SEG_LINE2;
				else if (func_q == clnw_pkg::FUNC_STRING && sts.wrap_hit)
					seg_next = clnw_pkg::SEG_CLEAR;
				else
					seg_next = clnw_pkg::SEG_NONE;
			end
			clnw_pkg::SEG_CLEAR: seg_next = (func_q == clnw_pkg::FUNC_STRING) ?
				clnw_pkg::SEG_HOME : clnw_pkg::SEG_NONE;
			clnw_pkg::SEG_WAIT_A: seg_next = clnw_pkg::SEG_WAIT_B;
			clnw_pkg::SEG_WAIT_B: seg_next = clnw_pkg::SEG_INIT_1;
			clnw_pkg::SEG_INIT_1: seg_next = clnw_pkg::SEG_INIT_2;
			clnw_pkg::SEG_INIT_2: seg_next = clnw_pkg::SEG_INIT_3;
			clnw_pkg::SEG_INIT_3: seg_next = clnw_pkg::SEG_INIT_4;
			clnw_pkg::SEG_INIT_4: seg_next = clnw_pkg::SEG_INIT_5;
			clnw_pkg::SEG_INIT_5: seg_next = clnw_pkg::SEG_WAIT_C;
			default:              seg_next = clnw_pkg::SEG_NONE;
		endcase
	end

	assign is_wait  = (seg_q == clnw_pkg::SEG_WAIT_A) || (seg_q == clnw_pkg::SEG_WAIT_B) ||
		(seg_q == clnw_pkg::SEG_WAIT_C);
	assign step_end = is_wait || low_q;

	always_comb begin
		cmd.capture = accept;
		cmd.load    = emit_go;
		cmd.seg     = seg_q;
		cmd.low     = low_q;
		cmd.last    = step_end && (seg_next == clnw_pkg::SEG_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= clnw_pkg::SEG_NONE;
			low_q       <= 1'b0;
			func_q      <= clnw_pkg::FUNC_CHAR;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
				if (step_end) begin
					seg_q <= seg_next;
					low_q <= 1'b0;
					if (seg_next == clnw_pkg::SEG_NONE)
						state_q <= ST_IDLE;
				end else begin
					low_q <= 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				func_q <= func;
				if (seg_first != clnw_pkg::SEG_NONE) begin
					state_q <= ST_EMIT;
					seg_q   <= seg_first;
					low_q   <= 1'b0;
				end
			end
		end
	end

endmodule

### hw/rtl/clnw_dp.sv
// ----------------------------------------------------------------------------
// clnw_dp
// datapath: config registers, string counter, item fields and result register
// ----------------------------------------------------------------------------
module clnw_dp #(
	parameter int CHARS_PER_LINE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [2:0]          func,
	input  logic [7:0]          data_byte,
	input  logic                string_start,
	input  logic [1:0]          row,
	input  logic [5:0]          column,
	input  clnw_pkg::clnw_cmd_t cmd,
	output clnw_pkg::clnw_sts_t sts,
	output logic                kind,
	output logic                reg_select,
	output logic [3:0]          nibble,
	output logic [3:0]          wait_ms,
	output logic                last
);

	localparam int CntW = $clog2(2 * CHARS_PER_LINE + 1);
	localparam logic [CntW-1:0] LineCnt = CntW'(CHARS_PER_LINE);
	localparam logic [CntW-1:0] WrapCnt = CntW'(2 * CHARS_PER_LINE);

	logic [7:0]      init_1_q, init_2_q, init_3_q, init_4_q, init_5_q, clear_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_base;
	logic [CntW-1:0] count_inc;
	logic            line_q, wrap_q;
	logic [7:0]      data_q;
	logic            row_q;
	logic [5:0]      col_q;
	logic [7:0]      sel_byte;
	logic            sel_rs;
	logic            sel_wait;
	logic [3:0]      sel_ms;
	logic            kind_q, rs_q, last_q;
	logic [3:0]      nibble_q, ms_q;

	assign sts.line_hit = line_q;
	assign sts.wrap_hit = wrap_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_1_q <= clnw_pkg::RST_INIT_1;
			init_2_q <= clnw_pkg::RST_INIT_2;
			init_3_q <= clnw_pkg::RST_INIT_3;
			init_4_q <= clnw_pkg::RST_INIT_4;
			init_5_q <= clnw_pkg::RST_INIT_5;
			clear_q  <= clnw_pkg::RST_CLEAR;
		end else if (cfg_valid) begin
			case (cfg_index)
				clnw_pkg::CFG_INIT_1: init_1_q <= cfg_data;
				clnw_pkg::CFG_INIT_2: init_2_q <= cfg_data;
				clnw_pkg::CFG_INIT_3: init_3_q <= cfg_data;
				clnw_pkg::CFG_INIT_4: init_4_q <= cfg_data;
				clnw_pkg::CFG_INIT_5: init_5_q <= cfg_data;
				clnw_pkg::CFG_CLEAR:  clear_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// string counter
	assign count_base = string_start ? '0 : count_q;
	assign count_inc  = count_base + CntW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			line_q  <= 1'b0;
			wrap_q  <= 1'b0;
		end else if (cmd.capture && func == clnw_pkg::FUNC_STRING) begin
			if (data_byte == 8'd0) begin
				count_q <= count_base;
				line_q  <= 1'b0;
				wrap_q  <= 1'b0;
			end else begin
				line_q  <= (count_inc == LineCnt);
				wrap_q  <= (count_inc >= WrapCnt);
				count_q <= (count_inc >= WrapCnt) ? '0 : count_inc;
			end
		end
	end

	// item fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			data_q <= data_byte;
			row_q  <= (row == clnw_pkg::ROW_SECOND);
			col_q  <= column;
		end
	end

	// byte or wait of the current segment
	always_comb begin
		sel_byte = 8'd0;
		sel_rs   = 1'b0;
		sel_wait = 1'b0;
		sel_ms   = 4'd0;
		case (cmd.seg)
			clnw_pkg::SEG_DATA: begin
				sel_byte = data_q;
				sel_rs   = 1'b1;
			end
			clnw_pkg::SEG_LINE2:  sel_byte = clnw_pkg::CMD_LINE2;
			clnw_pkg::SEG_CLEAR:  sel_byte = clear_q;
			clnw_pkg::SEG_HOME:   sel_byte = clnw_pkg::CMD_HOME;
			clnw_pkg::SEG_CURSOR: sel_byte = clnw_pkg::CMD_HOME |
				(row_q ? clnw_pkg::CMD_ROW1 : 8'd0) | {2'b00, col_q};
			clnw_pkg::SEG_INIT_1: sel_byte = init_1_q;
			clnw_pkg::SEG_INIT_2: sel_byte = init_2_q;
			clnw_pkg::SEG_INIT_3: sel_byte = init_3_q;
			clnw_pkg::SEG_INIT_4: sel_byte = init_4_q;
			clnw_pkg::SEG_INIT_5: sel_byte = init_5_q;
			clnw_pkg::SEG_WAIT_A, clnw_pkg::SEG_WAIT_C: begin
				sel_wait = 1'b1;
				sel_ms   = clnw_pkg::WAIT_LONG;
			end
			clnw_pkg::SEG_WAIT_B: begin
				sel_wait = 1'b1;
				sel_ms   = clnw_pkg::WAIT_SHORT;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= sel_wait;
			rs_q     <= sel_rs;
			nibble_q <= sel_wait ? 4'd0 : (cmd.low ? sel_byte[3:0] : sel_byte[7:4]);
			ms_q     <= sel_ms;
			last_q   <= cmd.last;
		end
	end

	assign kind       = kind_q;
	assign reg_select = rs_q;
	assign nibble     = nibble_q;
	assign wait_ms    = ms_q;
	assign last       = last_q;

endmodule

### hw/rtl/char_lcd_nibble_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit
// 4-bit character lcd writer: turns operations into enable strobes and waits
// ----------------------------------------------------------------------------
// Each accepted operation becomes a run of results, one per cycle while the
// output does not stall: every byte is two strobe results (high nibble, then
// low nibble) and every millisecond delay is a wait result, with last set on
// the final one. A character, cursor or clear is one byte; a string character
// adds the line-2 command at the end of line one or clear and home on a wrap;
// init is two waits, five init bytes and a wait. Items with no result (string
// terminator, rows two and three, unused codes) are only accepted. The
// controller's sequencer issues the results into the output register; a new
// item is taken as soon as the last result of the previous one is there. The
// config port is always ready and is to be written only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit #(
	parameter int CHARS_PER_LINE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// config write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	// operation input
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [7:0] data_byte,
	input  logic       string_start,
	input  logic [1:0] row,
	input  logic [5:0] column,
	// result output, one transfer per strobe or wait
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic [3:0] wait_ms,
	output logic       last
);

	clnw_pkg::clnw_cmd_t cmd;
	clnw_pkg::clnw_sts_t sts;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: picks the segments of the operation and paces the results
	clnw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_byte (data_byte),
		.row       (row),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: config, string count, byte select and result register
	clnw_dp #(
		.CHARS_PER_LINE (CHARS_PER_LINE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.data_byte    (data_byte),
		.string_start (string_start),
		.row          (row),
		.column       (column),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.wait_ms      (wait_ms),
		.last         (last)
	);

endmodule
